// File: src/srd_pkg.sv
// ---------------------------------------------------------------------------
// srd_pkg - shared types and constants of the sync-framed record deframer
// Payload structs, event and warning codes, phase encoding, config layout.
// ---------------------------------------------------------------------------
`default_nettype none

package srd_pkg;

  // descriptor length limit in words
  localparam int unsigned MaxDescWords = 64;

  // configuration port geometry
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned DescLenW = 7;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SYNC_WORD  = 2'd0,
    CFG_END_WORD   = 2'd1,
    CFG_FILL_WORD  = 2'd2,
    CFG_DESC_WORDS = 2'd3
  } srd_cfg_idx_e;

  // result event codes
  typedef enum logic [1:0] {
    EV_SKIP   = 2'd0,
    EV_HEADER = 2'd1,
    EV_DATA   = 2'd2,
    EV_WARN   = 2'd3
  } srd_event_e;

  // warning codes
  typedef enum logic [1:0] {
    WARN_NONE       = 2'd0,
    WARN_SYNC_EXP   = 2'd1,
    WARN_SYNC_HDR   = 2'd2,
    WARN_EMPTY_REC  = 2'd3
  } srd_warn_e;

  // deframer phase
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HEAD = 2'd1,
    PH_DESC = 2'd2
  } srd_phase_e;

  // input beat
  typedef struct packed {
    logic [31:0] word;
    logic        net_order;
  } srd_in_t;

  // result beat
  typedef struct packed {
    srd_event_e  event_res;
    srd_warn_e   warn_code;
    logic [15:0] record_id;
    logic [15:0] frame_count;
    logic [31:0] data_word;
    logic [15:0] desc_index;
    logic [5:0]  word_index;
    logic        desc_last;
    logic        record_last;
    logic [31:0] total_descs;
    logic [31:0] total_records;
  } srd_out_t;

  // configuration register set
  typedef struct packed {
    logic [31:0]         sync_word;
    logic [31:0]         end_word;
    logic [31:0]         fill_word;
    logic [DescLenW-1:0] desc_words;
  } srd_cfg_t;

  // descriptor length in force: zero reads as one, clamp at the limit
  function automatic logic [DescLenW-1:0] eff_len(input logic [DescLenW-1:0] n);
    logic [DescLenW-1:0] r;
    r = n;
    if (r == '0) r = DescLenW'(1);
    if (r > DescLenW'(MaxDescWords)) r = DescLenW'(MaxDescWords);
    return r;
  endfunction

  // swap the two bytes of a half word
  function automatic logic [15:0] swap16(input logic [15:0] h);
    return {h[7:0], h[15:8]};
  endfunction

  // saturating increment of a 32-bit total
  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

endpackage

`default_nettype wire

// File: src/srd_cfg_regs.sv
// ---------------------------------------------------------------------------
// srd_cfg_regs - configuration register file
// Holds sync, end and fill words and the descriptor length.
// ---------------------------------------------------------------------------
`default_nettype none

module srd_cfg_regs import srd_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output srd_cfg_t                 cfg_o
);

  srd_cfg_t cfg_q, cfg_d;

  // writes are always taken
  assign cfg_ready_o = 1'b1;

  // register decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (srd_cfg_idx_e'(cfg_index_i))
        CFG_SYNC_WORD:  cfg_d.sync_word  = cfg_data_i;
        CFG_END_WORD:   cfg_d.end_word   = cfg_data_i;
        CFG_FILL_WORD:  cfg_d.fill_word  = cfg_data_i;
        CFG_DESC_WORDS: cfg_d.desc_words = cfg_data_i[DescLenW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_word  <= '0;
      cfg_q.end_word   <= '0;
      cfg_q.fill_word  <= '0;
      cfg_q.desc_words <= DescLenW'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: src/srd_deframe.sv
// ---------------------------------------------------------------------------
// srd_deframe - deframing state and per-word result logic
// Phase machine, descriptor/word counters, record state and saturating totals.
// ---------------------------------------------------------------------------
`default_nettype none

module srd_deframe import srd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,
  input  srd_in_t   item_i,
  input  srd_cfg_t  cfg_i,
  output srd_out_t  res_o
);

  srd_phase_e  phase_q, phase_d;
  logic [5:0]  word_cnt_q, word_cnt_d;
  logic [15:0] desc_cnt_q, desc_cnt_d;
  logic [15:0] frames_q, frames_d;
  logic [15:0] cur_id_q, cur_id_d;
  logic [31:0] desc_tot_q, desc_tot_d;
  logic [31:0] rec_tot_q, rec_tot_d;

  // shared decode
  logic                is_sync;
  logic                is_quiet;
  logic [15:0]         hdr_lo;
  logic [15:0]         hdr_hi;
  logic [15:0]         desc_cnt_inc;
  logic [DescLenW-1:0] len;
  logic                desc_end;
  logic                rec_end;

  assign is_sync      = (item_i.word == cfg_i.sync_word);
  assign is_quiet     = (item_i.word == cfg_i.end_word) ||
                        (item_i.word == cfg_i.fill_word);
  assign hdr_lo       = item_i.net_order ? swap16(item_i.word[15:0])  : item_i.word[15:0];
  assign hdr_hi       = item_i.net_order ? swap16(item_i.word[31:16]) : item_i.word[31:16];
  assign len          = eff_len(cfg_i.desc_words);
  assign desc_end     = ({1'b0, word_cnt_q} + DescLenW'(1)) >= len;
  assign desc_cnt_inc = desc_cnt_q + 16'd1;
  assign rec_end      = desc_end && (desc_cnt_inc == frames_q);

  // next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_HEAD: begin
        if (!is_sync) phase_d = (hdr_hi != '0) ? PH_DESC : PH_HUNT;
      end
      PH_DESC: begin
        if (rec_end) phase_d = PH_HUNT;
      end
      default: begin
        phase_d = is_sync ? PH_HEAD : PH_HUNT;
      end
    endcase
  end

  // result and record state
  always_comb begin
    word_cnt_d = word_cnt_q;
    desc_cnt_d = desc_cnt_q;
    frames_d   = frames_q;
    cur_id_d   = cur_id_q;
    desc_tot_d = desc_tot_q;
    rec_tot_d  = rec_tot_q;

    res_o.event_res   = EV_SKIP;
    res_o.warn_code   = WARN_NONE;
    res_o.record_id   = cur_id_q;
    res_o.frame_count = frames_q;
    res_o.data_word   = '0;
    res_o.desc_index  = '0;
    res_o.word_index  = '0;
    res_o.desc_last   = 1'b0;
    res_o.record_last = 1'b0;

    case (phase_q)
      PH_HEAD: begin
        if (is_sync) begin
          res_o.event_res = EV_WARN;
          res_o.warn_code = WARN_SYNC_HDR;
        end else begin
          res_o.record_id   = hdr_lo;
          res_o.frame_count = hdr_hi;
          if (hdr_hi != '0) begin
            cur_id_d        = hdr_lo;
            frames_d        = hdr_hi;
            desc_cnt_d      = '0;
            word_cnt_d      = '0;
            rec_tot_d       = sat_inc(rec_tot_q);
            res_o.event_res = EV_HEADER;
          end else begin
            res_o.event_res = EV_WARN;
            res_o.warn_code = WARN_EMPTY_REC;
          end
        end
      end
      PH_DESC: begin
        res_o.event_res  = EV_DATA;
        res_o.data_word  = item_i.word;
        res_o.desc_index = desc_cnt_q;
        res_o.word_index = word_cnt_q;
        if (desc_end) begin
          res_o.desc_last   = 1'b1;
          res_o.record_last = rec_end;
          word_cnt_d        = '0;
          desc_tot_d        = sat_inc(desc_tot_q);
          desc_cnt_d        = desc_cnt_inc;
        end else begin
          word_cnt_d = word_cnt_q + 6'd1;
        end
      end
      default: begin
        if (!is_sync && !is_quiet) begin
          res_o.event_res = EV_WARN;
          res_o.warn_code = WARN_SYNC_EXP;
        end
      end
    endcase

    res_o.total_descs   = desc_tot_d;
    res_o.total_records = rec_tot_d;
  end

  // state registers, updated once per processed beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      word_cnt_q <= '0;
      desc_cnt_q <= '0;
      frames_q   <= '0;
      cur_id_q   <= '0;
      desc_tot_q <= '0;
      rec_tot_q  <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      word_cnt_q <= word_cnt_d;
      desc_cnt_q <= desc_cnt_d;
      frames_q   <= frames_d;
      cur_id_q   <= cur_id_d;
      desc_tot_q <= desc_tot_d;
      rec_tot_q  <= rec_tot_d;
    end
  end

endmodule

`default_nettype wire

// File: src/sync_framed_record_deframer.sv
// ---------------------------------------------------------------------------
// sync_framed_record_deframer - splits a 32-bit word stream into records
// Hunts for the sync word, decodes the header, passes descriptor words on.
// ---------------------------------------------------------------------------
// Usage
//   in channel  : in_valid_i / in_ready_o, one stream word per beat
//   out channel : out_valid_o / out_ready_i, exactly one result beat per
//                 input beat, in order
//   cfg channel : cfg_valid_i / cfg_ready_o, index and data; always ready,
//                 write only while the block is idle
// Pipeline: a taken beat sits in the input register, is decoded against the
//   record state and moves into the output register once that register is
//   free or draining, where its result is offered.
// Throughput: one beat per cycle while out_ready_i stays high; the combinational
//   decode and state update between the input and output registers sets it.
// Reset: phase back to hunting, counters and totals cleared, config to its
//   reset values, both pipeline registers empty.
// Stall: when the receiver holds out_ready_i low the result is held and the
//   input register keeps its beat, or takes one more beat if it is empty,
//   then in_ready_o drops.
// ---------------------------------------------------------------------------
`default_nettype none

module sync_framed_record_deframer import srd_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input stream
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  srd_in_t                  in_data_i,
  // result stream
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output srd_out_t                 out_data_o,
  // configuration writes
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  srd_cfg_t cfg;
  srd_out_t res;

  logic     in_vld_q;
  srd_in_t  in_q;
  logic     out_vld_q;
  srd_out_t out_q;
  logic     step;

  // register file
  srd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // a buffered beat moves on when the output register is free or draining
  assign step       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // decode and record state
  srd_deframe u_deframe (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || out_ready_i) begin
      out_vld_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb - testbench of the sync-framed record deframer
// Streams directed and random words through the block under a series of
// register settings, predicts every result beat as its word is taken and
// compares the result beats field by field, in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srd_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandPhases = 10;
  localparam int unsigned PhaseWords = 130;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // block ports
  logic                in_valid = 1'b0;
  logic                in_ready;
  srd_in_t             in_beat = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  srd_out_t            out_beat;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // words waiting to go in, results waiting to come out
  srd_in_t  stream_words[$];
  srd_out_t due_results[$];
  int unsigned words_made = 0;

  // idling control
  int unsigned in_idle_pct = 0;
  int unsigned out_idle_pct = 0;
  bit          calm = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;

  int unsigned failures = 0;
  int unsigned cycles = 0;

  // register copies
  logic [31:0]         cfg_sync = '0;
  logic [31:0]         cfg_end = '0;
  logic [31:0]         cfg_fill = '0;
  logic [DescLenW-1:0] cfg_len = DescLenW'(1);

  // record state of the deframer
  srd_phase_e  state_ph = PH_HUNT;
  logic [5:0]  word_idx = '0;
  logic [15:0] desc_idx = '0;
  logic [15:0] descs_due = '0;
  logic [15:0] rec_id = '0;
  logic [31:0] descs_done = '0;
  logic [31:0] recs_done = '0;

  sync_framed_record_deframer DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_beat),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // run guard
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles == CycleLimit) begin
      $display("[sync_framed_record_deframer] ERROR");
      $finish;
    end
  end

  // descriptor length as the block applies it
  function automatic int unsigned desc_len_in_force();
    if (cfg_len == '0) return 1;
    if (32'(cfg_len) > MaxDescWords) return MaxDescWords;
    return 32'(cfg_len);
  endfunction

  // result of one stream word, advancing the record state
  function automatic srd_out_t deframe_beat(input srd_in_t beat);
    srd_out_t    r;
    logic [15:0] lo;
    logic [15:0] hi;
    int unsigned wnext;
    r = '0;
    r.event_res = EV_SKIP;
    r.warn_code = WARN_NONE;
    r.record_id = rec_id;
    r.frame_count = descs_due;
    case (state_ph)
      PH_HEAD: begin
        if (beat.word == cfg_sync) begin
          r.event_res = EV_WARN;
          r.warn_code = WARN_SYNC_HDR;
        end else begin
          lo = beat.word[15:0];
          hi = beat.word[31:16];
          if (beat.net_order) begin
            lo = {lo[7:0], lo[15:8]};
            hi = {hi[7:0], hi[15:8]};
          end
          r.record_id = lo;
          r.frame_count = hi;
          if (hi != '0) begin
            rec_id = lo;
            descs_due = hi;
            desc_idx = '0;
            word_idx = '0;
            if (recs_done != '1) recs_done = recs_done + 32'd1;
            state_ph = PH_DESC;
            r.event_res = EV_HEADER;
          end else begin
            // empty record: back to hunting, record state untouched
            r.event_res = EV_WARN;
            r.warn_code = WARN_EMPTY_REC;
            state_ph = PH_HUNT;
          end
        end
      end
      PH_DESC: begin
        r.event_res = EV_DATA;
        r.data_word = beat.word;
        r.desc_index = desc_idx;
        r.word_index = word_idx;
        wnext = 32'(word_idx) + 1;
        if (wnext >= desc_len_in_force()) begin
          r.desc_last = 1'b1;
          word_idx = '0;
          if (descs_done != '1) descs_done = descs_done + 32'd1;
          desc_idx = desc_idx + 16'd1;
          if (desc_idx == descs_due) begin
            r.record_last = 1'b1;
            state_ph = PH_HUNT;
          end
        end else begin
          word_idx = word_idx + 6'd1;
        end
      end
      default: begin
        state_ph = PH_HUNT;
        if (beat.word == cfg_sync) begin
          state_ph = PH_HEAD;
        end else if (beat.word != cfg_end && beat.word != cfg_fill) begin
          r.event_res = EV_WARN;
          r.warn_code = WARN_SYNC_EXP;
        end
      end
    endcase
    r.total_descs = descs_done;
    r.total_records = recs_done;
    return r;
  endfunction

  // stream driver: takes words from the queue, idles in bursts
  always @(posedge clk or negedge rst_n) begin : stream_drive
    logic took;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && in_ready;
      if (took) due_results = {due_results, deframe_beat(in_beat)};
      if (!in_valid || took) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (stream_words.size() > 0) begin
          in_valid <= 1'b1;
          in_beat <= stream_words.pop_front();
          if (!calm && $urandom_range(99) < in_idle_pct) gap_left = $urandom_range(1, 17);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void match_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failures = failures + 1;
    end
  endfunction

  // result monitor: checks each result beat, stalls in bursts
  always @(posedge clk or negedge rst_n) begin : result_check
    srd_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result beat with nothing expected");
          failures = failures + 1;
        end else begin
          want = due_results.pop_front();
          match_field("event_res", 32'(want.event_res), 32'(out_beat.event_res));
          match_field("warn_code", 32'(want.warn_code), 32'(out_beat.warn_code));
          match_field("record_id", 32'(want.record_id), 32'(out_beat.record_id));
          match_field("frame_count", 32'(want.frame_count), 32'(out_beat.frame_count));
          match_field("data_word", want.data_word, out_beat.data_word);
          match_field("desc_index", 32'(want.desc_index), 32'(out_beat.desc_index));
          match_field("word_index", 32'(want.word_index), 32'(out_beat.word_index));
          match_field("desc_last", 32'(want.desc_last), 32'(out_beat.desc_last));
          match_field("record_last", 32'(want.record_last), 32'(out_beat.record_last));
          match_field("total_descs", want.total_descs, out_beat.total_descs);
          match_field("total_records", want.total_records, out_beat.total_records);
        end
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(99) < out_idle_pct) stall_left = $urandom_range(1, 17);
      end
    end
  end

  // register write over the config channel
  task automatic cfg_write(input srd_cfg_idx_e idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SYNC_WORD:  cfg_sync = val;
      CFG_END_WORD:   cfg_end = val;
      CFG_FILL_WORD:  cfg_fill = val;
      CFG_DESC_WORDS: cfg_len = val[DescLenW-1:0];
      default: ;
    endcase
  endtask

  // wait until every word is in and every result is out
  task automatic settle();
    while (stream_words.size() != 0 || in_valid || due_results.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_word(input logic [31:0] w, input logic net);
    srd_in_t b;
    b.word = w;
    b.net_order = net;
    stream_words = {stream_words, b};
    words_made = words_made + 1;
  endtask

  // random word, now and then an end or fill marker, never the sync word
  function automatic logic [31:0] random_payload(input int unsigned marker_pct);
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(99) < marker_pct) w = ($urandom_range(1) != 0) ? cfg_end : cfg_fill;
    if (w == cfg_sync) w = w ^ 32'h1;
    return w;
  endfunction

  // header word in either byte order; nudge the id if it would read as sync
  function automatic logic [31:0] header_word(input logic [15:0] id, input logic [15:0] cnt,
                                              input logic net);
    logic [31:0] w;
    w = net ? {cnt[7:0], cnt[15:8], id[7:0], id[15:8]} : {cnt, id};
    if (w == cfg_sync) w[7:0] = ~w[7:0];
    return w;
  endfunction

  // sync, optional repeated sync, header, then keep descriptor words
  task automatic add_record(input int unsigned descs, input int unsigned keep,
                            input bit twin_sync);
    logic net;
    net = 1'($urandom_range(1));
    push_word(cfg_sync, 1'($urandom_range(1)));
    if (twin_sync) push_word(cfg_sync, 1'($urandom_range(1)));
    push_word(header_word(16'($urandom), descs[15:0], net), net);
    repeat (keep) push_word(random_payload(12), 1'($urandom_range(1)));
  endtask

  // mostly well-formed records, some broken ones and noise
  task automatic run_random(input int unsigned n);
    int unsigned stop;
    int unsigned pick;
    int unsigned len;
    int unsigned descs;
    @(negedge clk);
    stop = words_made + n;
    len = desc_len_in_force();
    while (words_made < stop) begin
      pick = $urandom_range(99);
      descs = (len > 8) ? $urandom_range(1, 2) : $urandom_range(1, 5);
      if (pick < 70) begin
        add_record(descs, descs * len, 1'b0);
      end else if (pick < 78) begin
        // truncated record: the next words land inside it
        add_record(descs, $urandom_range(descs * len - 1), 1'b0);
      end else if (pick < 84) begin
        add_record(descs, descs * len, 1'b1);
      end else if (pick < 89) begin
        add_record(0, 0, 1'b0);
      end else begin
        repeat ($urandom_range(1, 4)) push_word(random_payload(60), 1'($urandom_range(1)));
      end
    end
  endtask

  function automatic logic [31:0] config_word(input logic [31:0] sync);
    case ($urandom_range(9))
      0: return sync;
      1: return '0;
      2: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DescLenW-1:0] pick_len();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) return DescLenW'($urandom_range(1, 4));
    if (pick < 70) return DescLenW'($urandom_range(5, 16));
    if (pick < 80) return DescLenW'($urandom_range(17, 63));
    if (pick < 88) return '0;
    if (pick < 94) return DescLenW'(MaxDescWords);
    return DescLenW'($urandom_range(65, 127));
  endfunction

  function automatic int unsigned idle_pct();
    case ($urandom_range(2))
      0: return 0;
      1: return 8;
      default: return 30;
    endcase
  endfunction

  // stimulus
  initial begin : stimulus
    int unsigned         ph;
    logic [31:0]         s;
    logic [31:0]         e;
    logic [31:0]         f;
    logic [DescLenW-1:0] l;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    in_idle_pct = 30;
    out_idle_pct = 30;

    // reset settings: sync, end and fill all zero, one-word descriptors
    @(negedge clk);
    push_word(32'h8000_0001, 1'b1);  // stray word while hunting
    push_word(32'h0000_0000, 1'b0);  // sync
    push_word(32'h0000_0000, 1'b1);  // sync where the header belongs
    push_word(32'h0002_ABCD, 1'b0);  // header, two descriptors
    push_word(32'hFFFF_FFFF, 1'b1);
    push_word(32'h0000_0000, 1'b1);  // sync value passed as data
    push_word(32'h0000_0000, 1'b0);
    push_word(32'h0000_FFFF, 1'b0);  // empty record
    push_word(32'h0000_0000, 1'b0);
    push_word(32'h0100_3412, 1'b1);  // byte-swapped header
    push_word(32'h5A5A_A5A5, 1'b0);
    settle();

    // markers while hunting, then a length change inside a descriptor
    cfg_write(CFG_SYNC_WORD, 32'hFFFF_FFFF);
    cfg_write(CFG_END_WORD, 32'h1357_9BDF);
    cfg_write(CFG_FILL_WORD, 32'h0000_0000);
    cfg_write(CFG_DESC_WORDS, 32'd3);
    @(negedge clk);
    push_word(32'h1357_9BDF, 1'b1);
    push_word(32'h0000_0000, 1'b0);
    push_word(32'h7FFF_FFFE, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(32'h0001_0007, 1'b0);
    push_word(32'h0123_4567, 1'b1);
    push_word(32'h89AB_CDEF, 1'b0);
    settle();
    cfg_write(CFG_DESC_WORDS, 32'd2);
    @(negedge clk);
    push_word(32'h2468_ACE0, 1'b0);
    settle();

    // zero length reads as one word
    cfg_write(CFG_DESC_WORDS, 32'd0);
    @(negedge clk);
    push_word(32'hFFFF_FFFF, 1'b1);
    push_word(32'h0002_0000, 1'b0);
    push_word(32'hC3C3_3C3C, 1'b1);
    push_word(32'h1111_2222, 1'b0);
    settle();

    // random phases, each under its own settings
    for (ph = 0; ph < RandPhases; ph++) begin
      @(negedge clk);
      s = $urandom;
      e = config_word(s);
      f = config_word(s);
      l = pick_len();
      case (ph)
        0: begin
          s = '1;
          l = DescLenW'(1);
        end
        1: begin
          s = '0;
          e = '1;
          l = DescLenW'(MaxDescWords);
        end
        2: begin
          f = s;
          l = '1;
        end
        3: l = '0;
        default: ;
      endcase
      cfg_write(CFG_SYNC_WORD, s);
      cfg_write(CFG_END_WORD, e);
      cfg_write(CFG_FILL_WORD, f);
      cfg_write(CFG_DESC_WORDS, 32'(l));
      calm = (ph == RandPhases - 1);
      in_idle_pct = calm ? 0 : idle_pct();
      out_idle_pct = calm ? 0 : idle_pct();
      run_random(PhaseWords);
      // largest descriptor count, left open at the end of the run
      if (calm) add_record(16'hFFFF, 24, 1'b0);
      settle();
    end

    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("[sync_framed_record_deframer] OK");
    end else begin
      $display("[sync_framed_record_deframer] ERROR");
    end
    $finish;
  end

endmodule
